/* rtl/core/s256prd_pkg.sv */
// s256prd_pkg: shared types, constants and round functions for the SHA-256
// paired-round difference block. No dependencies.
package s256prd_pkg;

    localparam int WordW     = 32;
    localparam int NumWords  = 16;
    localparam int NumRounds = 64;
    localparam int NumWork   = 8;
    localparam int WeightW   = 9;
    localparam int CountW    = 6;

    localparam logic [WordW-1:0] FlipMask = 32'h8000_0000;

    // index 0 is the first message word
    typedef logic [NumWords-1:0][WordW-1:0] t_block;
    // index 0 is working word a, index 7 is h
    typedef logic [NumWork-1:0][WordW-1:0]  t_work;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LOAD,
        BK_ROUND,
        BK_COUNT,
        BK_DONE
    } t_back_state;

    localparam logic [WordW-1:0] RoundK [NumRounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // h down to a
    localparam t_work InitValue = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic logic [WordW-1:0] rotr(logic [WordW-1:0] x, int unsigned n);
        return (x >> n) | (x << (WordW - n));
    endfunction

    // SWAR popcount, five levels of narrow adds
    function automatic logic [CountW-1:0] popcount32(logic [WordW-1:0] x);
        logic [WordW-1:0] s1, s2, s3, s4, s5;
        s1 = (x  & 32'h5555_5555) + ((x  >> 1)  & 32'h5555_5555);
        s2 = (s1 & 32'h3333_3333) + ((s1 >> 2)  & 32'h3333_3333);
        s3 = (s2 & 32'h0f0f_0f0f) + ((s2 >> 4)  & 32'h0f0f_0f0f);
        s4 = (s3 & 32'h00ff_00ff) + ((s3 >> 8)  & 32'h00ff_00ff);
        s5 = (s4 & 32'h0000_ffff) + ((s4 >> 16) & 32'h0000_ffff);
        return s5[CountW-1:0];
    endfunction

    // W[t+16] from the window W[t..t+15]
    function automatic logic [WordW-1:0] next_sched(t_block w);
        logic [WordW-1:0] sg0, sg1;
        sg0 = rotr(w[1], 7)   ^ rotr(w[1], 18)  ^ (w[1] >> 3);
        sg1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
        return sg1 + w[9] + sg0 + w[0];
    endfunction

    function automatic t_work sha_round(t_work w, logic [WordW-1:0] k,
                                        logic [WordW-1:0] wt);
        logic [WordW-1:0] s1, ch, s0, maj, t1, t2;
        t_work            r;
        s1  = rotr(w[4], 6) ^ rotr(w[4], 11) ^ rotr(w[4], 25);
        ch  = (w[4] & w[5]) ^ (~w[4] & w[6]);
        s0  = rotr(w[0], 2) ^ rotr(w[0], 13) ^ rotr(w[0], 22);
        maj = (w[0] & w[1]) ^ (w[0] & w[2]) ^ (w[1] & w[2]);
        t1  = w[7] + s1 + ch + k + wt;
        t2  = s0 + maj;
        r[7] = w[6];
        r[6] = w[5];
        r[5] = w[4];
        r[4] = w[3] + t1;
        r[3] = w[2];
        r[2] = w[1];
        r[1] = w[0];
        r[0] = t1 + t2;
        return r;
    endfunction

endpackage

/* rtl/core/s256prd_front.sv */
// s256prd_front: collects sixteen message words into one block and pushes
// it to the block queue. Depends on s256prd_pkg.
module s256prd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [s256prd_pkg::WordW-1:0] i_message_word,
    output logic                          o_stall,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output s256prd_pkg::t_block           o_q_block
);

    logic [3:0]          r_cnt;
    logic [3:0]          n_cnt;
    s256prd_pkg::t_block r_words;
    logic                accept;

    // only the closing word of a block needs queue space
    assign o_stall = (r_cnt == 4'd15) && i_q_full;
    assign accept  = i_valid && !o_stall;
    assign o_q_push = accept && (r_cnt == 4'd15);

    always_comb begin
        o_q_block     = r_words;
        o_q_block[15] = i_message_word;
        n_cnt         = accept ? r_cnt + 4'd1 : r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 4'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_words[r_cnt] <= i_message_word;
        end
    end

endmodule

/* rtl/core/s256prd_queue.sv */
// s256prd_queue: short block queue between front and back, registered read.
// Depends on s256prd_pkg.
module s256prd_queue #(
    parameter int DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  s256prd_pkg::t_block i_block,
    input  logic                i_pop,
    output s256prd_pkg::t_block o_block,
    output logic                o_full,
    output logic                o_empty
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    s256prd_pkg::t_block r_mem [DEPTH];
    s256prd_pkg::t_block r_rd_data;
    logic [PtrW-1:0]     r_wr, r_rd, n_wr, n_rd;
    logic [CntW-1:0]     r_cnt, n_cnt;
    logic                do_push, do_pop;

    assign o_full  = (r_cnt == FullCnt);
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_block = r_rd_data;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == LastPtr) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == LastPtr) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_block;
        end
        r_rd_data <= r_mem[r_rd];
    end

endmodule

/* rtl/core/s256prd_back.sv */
// s256prd_back: runs 64 rounds on the plain and flipped copies side by side,
// counts the difference bits and holds the result. Depends on s256prd_pkg.
module s256prd_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_empty,
    output logic                            o_q_pop,
    input  s256prd_pkg::t_block             i_q_block,
    input  logic                            i_stall,
    output logic                            o_valid,
    output s256prd_pkg::t_work              o_diff,
    output logic [s256prd_pkg::WeightW-1:0] o_weight
);

    s256prd_pkg::t_back_state        r_state, n_state;
    logic [5:0]                      r_round, n_round;
    logic [2:0]                      r_cnt, n_cnt;
    s256prd_pkg::t_block             r_win_p, r_win_f, n_win_p, n_win_f;
    s256prd_pkg::t_work              r_work_p, r_work_f, n_work_p, n_work_f;
    logic [s256prd_pkg::WeightW-1:0] r_weight, n_weight;
    logic                            r_out_valid, n_out_valid;
    s256prd_pkg::t_work              r_out_diff, n_out_diff;
    logic [s256prd_pkg::WeightW-1:0] r_out_weight, n_out_weight;
    logic                            slot_free;

    assign slot_free = !r_out_valid || !i_stall;
    assign o_valid   = r_out_valid;
    assign o_diff    = r_out_diff;
    assign o_weight  = r_out_weight;

    always_comb begin
        n_state      = r_state;
        n_round      = r_round;
        n_cnt        = r_cnt;
        n_win_p      = r_win_p;
        n_win_f      = r_win_f;
        n_work_p     = r_work_p;
        n_work_f     = r_work_f;
        n_weight     = r_weight;
        n_out_valid  = r_out_valid && i_stall;
        n_out_diff   = r_out_diff;
        n_out_weight = r_out_weight;
        o_q_pop      = 1'b0;
        unique case (r_state)
            s256prd_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = s256prd_pkg::BK_LOAD;
                end
            end
            s256prd_pkg::BK_LOAD: begin
                n_win_p    = i_q_block;
                n_win_f    = i_q_block;
                n_win_f[0] = i_q_block[0] ^ s256prd_pkg::FlipMask;
                n_work_p   = s256prd_pkg::InitValue;
                n_work_f   = s256prd_pkg::InitValue;
                n_round    = 6'd0;
                n_state    = s256prd_pkg::BK_ROUND;
            end
            s256prd_pkg::BK_ROUND: begin
                n_work_p = s256prd_pkg::sha_round(r_work_p,
                               s256prd_pkg::RoundK[r_round], r_win_p[0]);
                n_work_f = s256prd_pkg::sha_round(r_work_f,
                               s256prd_pkg::RoundK[r_round], r_win_f[0]);
                n_win_p  = {s256prd_pkg::next_sched(r_win_p), r_win_p[15:1]};
                n_win_f  = {s256prd_pkg::next_sched(r_win_f), r_win_f[15:1]};
                n_round  = r_round + 6'd1;
                if (r_round == 6'd63) begin
                    n_cnt    = 3'd0;
                    n_weight = '0;
                    n_state  = s256prd_pkg::BK_COUNT;
                end
            end
            s256prd_pkg::BK_COUNT: begin
                // one word per cycle; eight rotations restore the order
                n_weight = r_weight + {3'b000,
                           s256prd_pkg::popcount32(r_work_p[0] ^ r_work_f[0])};
                n_work_p = {r_work_p[0], r_work_p[7:1]};
                n_work_f = {r_work_f[0], r_work_f[7:1]};
                n_cnt    = r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    n_state = s256prd_pkg::BK_DONE;
                end
            end
            s256prd_pkg::BK_DONE: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_diff   = r_work_p ^ r_work_f;
                    n_out_weight = r_weight;
                    n_state      = s256prd_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = s256prd_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= s256prd_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_round      <= n_round;
        r_cnt        <= n_cnt;
        r_win_p      <= n_win_p;
        r_win_f      <= n_win_f;
        r_work_p     <= n_work_p;
        r_work_f     <= n_work_f;
        r_weight     <= n_weight;
        r_out_diff   <= n_out_diff;
        r_out_weight <= n_out_weight;
    end

endmodule

/* rtl/core/sha256_pair_round_difference.sv */
// sha256_pair_round_difference: top level, front -> block queue -> back.
// Depends on s256prd_pkg, s256prd_front, s256prd_queue, s256prd_back.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  input   | in        | i_valid / o_stall  | i_message_word (one word/req)
//  output  | out       | o_valid / i_stall  | o_diff_a..o_diff_h, weight
//
// The front takes one word per cycle while o_stall is low; every sixteenth
// word closes a block and pushes it into a QUEUE_DEPTH-deep block queue.
// The back works on one block at a time: a queue read, 64 rounds at one
// round per cycle for both copies in parallel, bit counting (one difference
// word per cycle) and the hand-off of the result; only then is the next
// block popped from the queue.
// Reset is synchronous, active low; no clearing pass is needed.
// o_stall rises only on the closing word of a block while the queue is full;
// a held result in the output register lets the back finish the next block.
module sha256_pair_round_difference #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input request channel
    input  logic        i_valid,
    input  logic [31:0] i_message_word,
    output logic        o_stall,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_diff_a,
    output logic [31:0] o_diff_b,
    output logic [31:0] o_diff_c,
    output logic [31:0] o_diff_d,
    output logic [31:0] o_diff_e,
    output logic [31:0] o_diff_f,
    output logic [31:0] o_diff_g,
    output logic [31:0] o_diff_h,
    output logic [8:0]  o_difference_weight
);

    // front <-> queue
    logic                q_push;
    s256prd_pkg::t_block q_wr_block;
    logic                q_full;
    // queue <-> back
    logic                q_pop;
    logic                q_empty;
    s256prd_pkg::t_block q_rd_block;
    // back result, index 0 is word a
    s256prd_pkg::t_work  diff;

    s256prd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_message_word (i_message_word),
        .o_stall        (o_stall),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_block      (q_wr_block)
    );

    s256prd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_block (q_wr_block),
        .i_pop   (q_pop),
        .o_block (q_rd_block),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    s256prd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_q_block (q_rd_block),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_diff    (diff),
        .o_weight  (o_difference_weight)
    );

    assign o_diff_a = diff[0];
    assign o_diff_b = diff[1];
    assign o_diff_c = diff[2];
    assign o_diff_d = diff[3];
    assign o_diff_e = diff[4];
    assign o_diff_f = diff[5];
    assign o_diff_g = diff[6];
    assign o_diff_h = diff[7];

endmodule

/* rtl/core/s256prd_checker.sv */
// s256prd_checker: port-level checks on the result channel, bound to the top
// level. Depends on sha256_pair_round_difference ports only.
module s256prd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_diff_a,
    input logic [31:0] o_diff_b,
    input logic [31:0] o_diff_c,
    input logic [31:0] o_diff_d,
    input logic [31:0] o_diff_e,
    input logic [31:0] o_diff_f,
    input logic [31:0] o_diff_g,
    input logic [31:0] o_diff_h,
    input logic [8:0]  o_difference_weight
);

    logic [255:0] all_diff;
    assign all_diff = {o_diff_h, o_diff_g, o_diff_f, o_diff_e,
                       o_diff_d, o_diff_c, o_diff_b, o_diff_a};

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(all_diff)
                               && $stable(o_difference_weight))
        else $error("stalled result changed");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_difference_weight <= 9'd256)
        else $error("weight out of range");

    // weight parity must match the xor of all difference bits
    a_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_difference_weight[0] == ^all_diff)
        else $error("weight parity mismatch");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind sha256_pair_round_difference s256prd_checker u_s256prd_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_valid             (o_valid),
    .i_stall             (i_stall),
    .o_diff_a            (o_diff_a),
    .o_diff_b            (o_diff_b),
    .o_diff_c            (o_diff_c),
    .o_diff_d            (o_diff_d),
    .o_diff_e            (o_diff_e),
    .o_diff_f            (o_diff_f),
    .o_diff_g            (o_diff_g),
    .o_diff_h            (o_diff_h),
    .o_difference_weight (o_difference_weight)
);
